/* design/qsk_pkg.sv */
package qsk_pkg;

  // Store geometry
  localparam int unsigned MAX_CENTROIDS = 256;
  localparam int unsigned IDX_W         = $clog2(MAX_CENTROIDS);
  localparam int unsigned CNT_W         = IDX_W + 1;

  // Register reset values
  localparam logic [6:0] COMPRESSION_RST = 7'd100;
  localparam logic [7:0] MERGE_LIMIT_RST = 8'd200;

  // Q0.16 constants
  localparam logic [16:0] Q_ONE     = 17'h10000;
  localparam logic [17:0] FRAC_HALF = 18'd32768;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    CFG_COMPRESSION = 1'b0,
    CFG_MERGE_LIMIT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] mean;
    logic [31:0] weight;
  } entry_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } mem_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [33:0] divisor;
  } div_req_t;

endpackage

/* design/qsk_mem.sv */
module qsk_mem (
  input  logic              clk_i,
  input  qsk_pkg::mem_req_t req_i,
  output qsk_pkg::entry_t   rdata_o
);

  qsk_pkg::entry_t mem_q [qsk_pkg::MAX_CENTROIDS];
  qsk_pkg::entry_t rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/qsk_div.sv */
module qsk_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qsk_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [31:0]       quot_o
);

  // Restoring divider, one quotient bit per cycle. The upper dividend half
  // must be below the divisor, so 32 quotient bits suffice.
  logic [33:0] rem_q, rem_d;
  logic [33:0] dvs_q;
  logic [31:0] lo_q, lo_d;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [34:0] trial;
  logic        ge;

  assign trial = {rem_q, lo_q[31]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign rem_d = ge ? 34'(trial - {1'b0, dvs_q}) : trial[33:0];
  assign lo_d  = {lo_q[30:0], ge};

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {2'b00, req_i.dividend[63:32]};
      lo_q  <= req_i.dividend[31:0];
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      lo_q  <= lo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = lo_q;

endmodule

/* design/streaming_quantile_sketch.sv */
// Streaming quantile sketch: centroids sorted by mean in one on-chip memory.
// Input channel (in_valid_i/in_ready_o) carries a command: add a Q16.16
// sample, or ask the Q0.16 quantile. Every transfer yields exactly one result
// on the output channel (out_valid_o/out_ready_i): estimate plus status.
// One item is processed at a time; in_ready_o is high only when idle.
// Processing steps, from the input transfer to the result:
//   add     : the insert walk reads and shifts centroids up one at a time from
//             the top; when the count passes merge_limit, a merge pass reads each
//             centroid and runs the 32-step divider for every joined pair
//   query   : a single read on the first/last/all-unit paths, otherwise a walk
//             over the centroids plus the divider for the interpolation
// The walks are serial: the memory has a single read port and the divider is serial.
// A result waits in an output register; the next item may be taken while it
// waits, and a later result holds its state until the register frees up.
// Reset empties the store (count and total weight zero) and restores
// compression=100, merge_limit=200. The config port write is registered; the port
// is used only while idle, a rule for the user that the block itself does not enforce.
module streaming_quantile_sketch (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [31:0] sample_value_i,
  input  logic [16:0] quantile_fraction_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] quantile_value_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned CW = qsk_pkg::CNT_W;
  localparam int unsigned AW = qsk_pkg::IDX_W;
  localparam logic signed [51:0] RES_MAX = 52'sh0_0000_7FFF_FFFF;
  localparam logic signed [51:0] RES_MIN = -52'sh0_0000_8000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_RD, S_ADD_CMP, S_ADD_DONE,
    S_MRG_RD, S_MRG_CHK, S_MRG_MUL0, S_MRG_MUL1, S_MRG_SUM, S_MRG_GO, S_MRG_DIV,
    S_Q_RD, S_Q_CHK, S_Q_GO, S_Q_DIV, S_Q_MUL, S_Q_FIN, S_Q_ANS, S_RESULT
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      count_q;
  logic [31:0]        total_q;
  logic [6:0]         comp_q;
  logic [7:0]         mlimit_q;
  logic               out_valid_q;
  logic [31:0]        out_value_q;
  logic [1:0]         out_status_q;
  logic [31:0]        res_value_q;
  qsk_pkg::status_e   res_status_q;
  logic [31:0]        sample_q;
  logic [CW-1:0]      k_q;
  logic [CW-1:0]      outn_q;
  logic [31:0]        bm_q;
  logic [31:0]        bw_q;
  logic [31:0]        m1_q;
  logic [31:0]        w1_q;
  logic [32:0]        nw_q;
  logic signed [64:0] p0_q, p1_q;
  logic [63:0]        num_abs_q;
  logic               num_neg_q;
  logic [47:0]        target_q;
  logic [39:0]        cum_q;
  logic [47:0]        left_q;
  logic signed [17:0] frac_q;
  logic signed [50:0] prod_q;

  qsk_pkg::mem_req_t  mem_req;
  qsk_pkg::entry_t    rd;
  qsk_pkg::div_req_t  div_req;
  logic               div_done;
  logic [31:0]        div_quot;

  qsk_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rd)
  );

  qsk_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Datapath helpers
  logic               in_xfer;
  logic [CW-1:0]      km1, kp1, cntm1, outm1;
  logic [CW-1:0]      idx_raw, idx_sel, fast_addr;
  logic [24:0]        idx_prod;
  logic               unit_wts, fast_q;
  logic [47:0]        target_w;
  logic [6:0]         comp_eff;
  logic [32:0]        nw_w;
  logic [39:0]        nw_comp;
  logic               join_ok;
  logic [39:0]        cum_next;
  logic               reach;
  logic [47:0]        left_w;
  logic signed [65:0] num_sum, num_abs;
  logic [31:0]        mrg_mean;
  logic signed [32:0] mdiff;
  logic signed [51:0] res_full;
  logic [31:0]        res_sat;
  logic               out_free;
  logic               add_greater;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign km1       = k_q - CW'(1);
  assign kp1       = k_q + CW'(1);
  assign cntm1     = count_q - CW'(1);
  assign outm1     = outn_q - CW'(1);
  assign out_free  = !out_valid_q || out_ready_i;

  // Query fast paths: every weight is one exactly when the total equals the count
  assign unit_wts  = total_q == 32'(count_q);
  assign idx_prod  = quantile_fraction_i[15:0] * count_q;
  assign idx_raw   = idx_prod[24:16];
  assign idx_sel   = (idx_raw > cntm1) ? cntm1 : idx_raw;
  assign fast_q    = (quantile_fraction_i == '0) || (quantile_fraction_i >= qsk_pkg::Q_ONE)
                     || unit_wts;
  assign fast_addr = (quantile_fraction_i == '0) ? '0 :
                     (quantile_fraction_i >= qsk_pkg::Q_ONE) ? cntm1 : idx_sel;
  assign target_w  = quantile_fraction_i[15:0] * total_q;

  // Insert walk compare
  assign add_greater = $signed(rd.mean) > $signed(sample_q);

  // Merge join test
  assign comp_eff = (comp_q == '0) ? 7'd1 : comp_q;
  assign nw_w     = {1'b0, bw_q} + {1'b0, rd.weight};
  assign nw_comp  = nw_w * comp_eff;
  assign join_ok  = nw_comp <= {8'b0, total_q};
  assign num_sum  = 66'(p0_q) + 66'(p1_q);
  assign num_abs  = num_sum[65] ? 66'(-num_sum) : num_sum;
  assign mrg_mean = num_neg_q ? 32'(-div_quot) : div_quot;

  // Query walk
  assign cum_next = cum_q + {8'b0, rd.weight};
  assign reach    = {cum_next, 16'b0} >= {8'b0, target_q};
  assign left_w   = target_q - {cum_q[31:0], 16'b0};
  assign mdiff    = $signed({m1_q[31], m1_q}) - $signed({bm_q[31], bm_q});
  assign res_full = 52'($signed(bm_q)) + 52'(prod_q >>> 16);
  assign res_sat  = (res_full > RES_MAX) ? 32'h7FFF_FFFF :
                    (res_full < RES_MIN) ? 32'h8000_0000 : res_full[31:0];

  // Memory port requests
  always_comb begin
    mem_req = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && command_i == qsk_pkg::CMD_QUERY && count_q != '0 && fast_q) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = fast_addr[AW-1:0];
        end
      end
      S_ADD_RD: begin
        if (k_q == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = '0;
          mem_req.wdata = '{mean: sample_q, weight: 32'd1};
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = km1[AW-1:0];
        end
      end
      S_ADD_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = k_q[AW-1:0];
        mem_req.wdata = add_greater ? rd : qsk_pkg::entry_t'{mean: sample_q, weight: 32'd1};
      end
      S_MRG_RD: begin
        if (k_q == count_q) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = outm1[AW-1:0];
          mem_req.wdata = '{mean: bm_q, weight: bw_q};
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = k_q[AW-1:0];
        end
      end
      S_MRG_CHK: begin
        if (outn_q != '0 && !join_ok) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = outm1[AW-1:0];
          mem_req.wdata = '{mean: bm_q, weight: bw_q};
        end
      end
      S_Q_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = (k_q == count_q) ? cntm1[AW-1:0] : k_q[AW-1:0];
      end
      S_Q_CHK: begin
        if (reach && kp1 < count_q) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = kp1[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  // Divider requests
  always_comb begin
    div_req.start    = (state_q == S_MRG_GO) || (state_q == S_Q_GO);
    div_req.dividend = (state_q == S_Q_GO) ? {16'b0, left_q} : num_abs_q;
    div_req.divisor  = (state_q == S_Q_GO) ? {2'b00, w1_q} : {1'b0, nw_q};
  end

  // Sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      total_q      <= '0;
      comp_q       <= qsk_pkg::COMPRESSION_RST;
      mlimit_q     <= qsk_pkg::MERGE_LIMIT_RST;
      out_valid_q  <= 1'b0;
      res_status_q <= qsk_pkg::ST_OK;
    end else begin
      if (cfg_we_i) begin
        unique case (qsk_pkg::cfg_idx_e'(cfg_index_i))
          qsk_pkg::CFG_COMPRESSION: comp_q   <= cfg_data_i[6:0];
          qsk_pkg::CFG_MERGE_LIMIT: mlimit_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Output register empties on its transfer unless refilled below
      if (out_valid_q && out_ready_i && state_q != S_RESULT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            sample_q     <= sample_value_i;
            res_value_q  <= '0;
            if (command_i == qsk_pkg::CMD_ADD) begin
              if (count_q == CW'(qsk_pkg::MAX_CENTROIDS)) begin
                res_status_q <= qsk_pkg::ST_FULL;
                state_q      <= S_RESULT;
              end else begin
                res_status_q <= qsk_pkg::ST_OK;
                k_q          <= count_q;
                state_q      <= S_ADD_RD;
              end
            end else if (count_q == '0) begin
              res_status_q <= qsk_pkg::ST_EMPTY;
              state_q      <= S_RESULT;
            end else if (fast_q) begin
              res_status_q <= qsk_pkg::ST_OK;
              state_q      <= S_Q_ANS;
            end else begin
              res_status_q <= qsk_pkg::ST_OK;
              target_q     <= target_w;
              cum_q        <= '0;
              k_q          <= '0;
              state_q      <= S_Q_RD;
            end
          end
        end

        // Sorted insert: shift entries up from the top until the slot is found
        S_ADD_RD: begin
          state_q <= (k_q == '0) ? S_ADD_DONE : S_ADD_CMP;
        end
        S_ADD_CMP: begin
          if (add_greater) begin
            k_q     <= km1;
            state_q <= S_ADD_RD;
          end else begin
            state_q <= S_ADD_DONE;
          end
        end
        S_ADD_DONE: begin
          count_q <= count_q + CW'(1);
          if (total_q != '1) begin
            total_q <= total_q + 32'd1;
          end
          if ((count_q + CW'(1)) > CW'(mlimit_q) && count_q != '0) begin
            k_q     <= '0;
            outn_q  <= '0;
            state_q <= S_MRG_RD;
          end else begin
            state_q <= S_RESULT;
          end
        end

        // Merge pass: running bucket held in registers, flushed on close
        S_MRG_RD: begin
          if (k_q == count_q) begin
            count_q <= outn_q;
            state_q <= S_RESULT;
          end else begin
            state_q <= S_MRG_CHK;
          end
        end
        S_MRG_CHK: begin
          if (outn_q == '0) begin
            bm_q    <= rd.mean;
            bw_q    <= rd.weight;
            outn_q  <= CW'(1);
            k_q     <= kp1;
            state_q <= S_MRG_RD;
          end else if (join_ok) begin
            m1_q    <= rd.mean;
            w1_q    <= rd.weight;
            nw_q    <= nw_w;
            state_q <= S_MRG_MUL0;
          end else begin
            bm_q    <= rd.mean;
            bw_q    <= rd.weight;
            outn_q  <= outn_q + CW'(1);
            k_q     <= kp1;
            state_q <= S_MRG_RD;
          end
        end
        S_MRG_MUL0: begin
          p0_q    <= $signed(bm_q) * $signed({1'b0, bw_q});
          state_q <= S_MRG_MUL1;
        end
        S_MRG_MUL1: begin
          p1_q    <= $signed(m1_q) * $signed({1'b0, w1_q});
          state_q <= S_MRG_SUM;
        end
        S_MRG_SUM: begin
          num_abs_q <= num_abs[63:0];
          num_neg_q <= num_sum[65];
          state_q   <= S_MRG_GO;
        end
        S_MRG_GO: begin
          state_q <= S_MRG_DIV;
        end
        S_MRG_DIV: begin
          if (div_done) begin
            bm_q    <= mrg_mean;
            bw_q    <= nw_q[31:0];
            k_q     <= kp1;
            state_q <= S_MRG_RD;
          end
        end

        // Query walk over cumulative weight
        S_Q_RD: begin
          state_q <= (k_q == count_q) ? S_Q_ANS : S_Q_CHK;
        end
        S_Q_CHK: begin
          if (reach) begin
            if (kp1 >= count_q) begin
              res_value_q <= rd.mean;
              state_q     <= S_RESULT;
            end else begin
              bm_q    <= rd.mean;
              w1_q    <= rd.weight;
              left_q  <= left_w;
              state_q <= S_Q_GO;
            end
          end else begin
            cum_q   <= cum_next;
            k_q     <= kp1;
            state_q <= S_Q_RD;
          end
        end
        S_Q_GO: begin
          m1_q    <= rd.mean;
          state_q <= S_Q_DIV;
        end
        S_Q_DIV: begin
          if (div_done) begin
            frac_q  <= $signed({1'b0, div_quot[16:0]}) - $signed(qsk_pkg::FRAC_HALF);
            state_q <= S_Q_MUL;
          end
        end
        S_Q_MUL: begin
          prod_q  <= frac_q * mdiff;
          state_q <= S_Q_FIN;
        end
        S_Q_FIN: begin
          res_value_q <= res_sat;
          state_q     <= S_RESULT;
        end
        S_Q_ANS: begin
          res_value_q <= rd.mean;
          state_q     <= S_RESULT;
        end

        // Hand the result to the output register
        S_RESULT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_value_q  <= res_value_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o       = state_q == S_IDLE;
  assign out_valid_o      = out_valid_q;
  assign quantile_value_o = out_value_q;
  assign status_o         = out_status_q;

endmodule

/* design/qsk_checker.sv */
module qsk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] quantile_value_o,
  input logic [1:0]  status_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(quantile_value_o)
      && $stable(status_o))
    else $error("result changed while stalled");

  // Error and drop results carry a zero estimate
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != qsk_pkg::ST_OK |-> quantile_value_o == '0)
    else $error("nonzero value with error status");

  // One item at a time: busy right after a transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after input transfer");

  // Ready drops only because of an input transfer
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o))
    else $error("ready fell without a transfer");

endmodule

bind streaming_quantile_sketch qsk_checker u_qsk_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .quantile_value_o (quantile_value_o),
  .status_o         (status_o)
);
